FILE: sv/ipv4dq_pkg.sv
package ipv4dq_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [1:0]  LAST_OCTET  = 2'd3;
   localparam logic [1:0]  MAX_DIGITS  = 2'd3;
   localparam logic [3:0]  COUNT_MAX   = 4'hf;
   localparam logic [11:0] OCTET_LIMIT = 12'd255;
   localparam logic [3:0]  MIN_CONSUMED = 4'd7;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] address;
      logic [3:0]  consumed;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  octet_idx;
      logic [1:0]  ndigits;
      logic [7:0]  octet_value;
      logic [23:0] address_acc;
      logic [3:0]  byte_count;
      logic        discarding;
   } parse_state_type;

endpackage

FILE: sv/ipv4_dotted_quad_parser.sv
// Parses a strict dotted-quad IPv4 address from a stream of ASCII bytes, one byte per
// word, with last_byte marking the final byte of each buffer. Each buffer yields exactly
// one result word: success with the address and byte count on a space or NUL after the
// fourth octet, or failure on the first bad byte or on an unterminated last byte. Bytes
// after a result are dropped until the last byte of the buffer. Each accepted byte is
// held in an input register, passes through the parser transition logic, and its
// result (if any) is loaded into the output register when that register is empty or being read.
// One byte is accepted every cycle as long as the result side keeps taking words.
module ipv4_dotted_quad_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ipv4dq_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ipv4dq_pkg::rsp_word_type rsp_word
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   ipv4dq_pkg::req_word_type    in_word_ff;
   ipv4dq_pkg::req_word_type    in_word_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   ipv4dq_pkg::rsp_word_type    out_word_ff;
   ipv4dq_pkg::rsp_word_type    out_word_in;
   ipv4dq_pkg::parse_state_type state_ff;
   ipv4dq_pkg::parse_state_type state_in;
   ipv4dq_pkg::parse_state_type step_state;
   logic                        step_valid;
   ipv4dq_pkg::rsp_word_type    step_word;
   logic                        advance;

   ipv4dq_step u_step (
      .cur_state    (state_ff),
      .word         (in_word_ff),
      .nxt_state    (step_state),
      .result_valid (step_valid),
      .result_word  (step_word)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_word_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in = in_word_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_word_in = req_word;
      end
      state_in = advance ? step_state : state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_word_in = out_word_ff;
      if (advance && step_valid) begin
         out_valid_in = 1'b1;
         out_word_in = step_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
      in_word_ff <= in_word_in;
      out_word_ff <= out_word_in;
   end

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.ok) |-> (rsp_word.address == 32'd0 && rsp_word.consumed == 4'd0))
      else $error("failure word carries nonzero fields");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.ok) |-> (rsp_word.consumed >= ipv4dq_pkg::MIN_CONSUMED))
      else $error("successful parse shorter than a minimal address");

   a_discard_set: assert property (@(posedge clock) disable iff (reset)
      (advance && step_valid && !in_word_ff.last_byte) |=> state_ff.discarding)
      else $error("result in mid buffer did not start discarding");

   a_discard_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.discarding |-> (state_ff.ndigits == 2'd0 && state_ff.octet_idx == 2'd0 &&
                               state_ff.byte_count == 4'd0))
      else $error("parser state not cleared while discarding");

endmodule

FILE: sv/ipv4dq_step.sv
module ipv4dq_step (
   input  ipv4dq_pkg::parse_state_type cur_state,
   input  ipv4dq_pkg::req_word_type    word,
   output ipv4dq_pkg::parse_state_type nxt_state,
   output logic                        result_valid,
   output ipv4dq_pkg::rsp_word_type    result_word
);

   logic        digit;
   logic [3:0]  digit_value;
   logic [7:0]  digit_offset;
   logic [11:0] octet_next;
   logic        fail;
   logic        done;

   assign digit = word.byte_in inside {[ipv4dq_pkg::CHAR_ZERO:ipv4dq_pkg::CHAR_NINE]};
   assign digit_offset = word.byte_in - ipv4dq_pkg::CHAR_ZERO;
   assign digit_value = digit_offset[3:0];
   assign octet_next = ({4'd0, cur_state.octet_value} * 12'd10) + {8'd0, digit_value};

   always_comb begin
      nxt_state = cur_state;
      result_valid = 1'b0;
      result_word = '0;
      fail = 1'b0;
      done = 1'b0;
      if (cur_state.discarding) begin
         if (word.last_byte) begin
            nxt_state = '0;
         end
      end else begin
         if (cur_state.ndigits == 2'd0) begin
            if (digit) begin
               nxt_state.octet_value = {4'd0, digit_value};
               nxt_state.ndigits = 2'd1;
            end else begin
               fail = 1'b1;
            end
         end else if (cur_state.octet_idx != ipv4dq_pkg::LAST_OCTET &&
                      word.byte_in == ipv4dq_pkg::CHAR_DOT) begin
            nxt_state.address_acc = {cur_state.address_acc[15:0], cur_state.octet_value};
            nxt_state.octet_value = 8'd0;
            nxt_state.octet_idx = cur_state.octet_idx + 2'd1;
            nxt_state.ndigits = 2'd0;
         end else if (cur_state.octet_idx == ipv4dq_pkg::LAST_OCTET &&
                      (word.byte_in == ipv4dq_pkg::CHAR_SPACE ||
                       word.byte_in == ipv4dq_pkg::CHAR_NUL)) begin
            done = 1'b1;
         end else if (digit && cur_state.ndigits != ipv4dq_pkg::MAX_DIGITS) begin
            // A digit after a lone zero is a leading zero.
            if ((cur_state.ndigits == 2'd1 && cur_state.octet_value == 8'd0) ||
                octet_next > ipv4dq_pkg::OCTET_LIMIT) begin
               fail = 1'b1;
            end else begin
               nxt_state.octet_value = octet_next[7:0];
               nxt_state.ndigits = cur_state.ndigits + 2'd1;
            end
         end else begin
            fail = 1'b1;
         end

         if (done) begin
            result_valid = 1'b1;
            result_word.ok = 1'b1;
            result_word.address = {cur_state.address_acc, cur_state.octet_value};
            result_word.consumed = cur_state.byte_count;
         end else begin
            if (!fail && cur_state.byte_count != ipv4dq_pkg::COUNT_MAX) begin
               nxt_state.byte_count = cur_state.byte_count + 4'd1;
            end
            if (fail || word.last_byte) begin
               result_valid = 1'b1;
            end
         end

         if (result_valid) begin
            nxt_state = '0;
            nxt_state.discarding = !word.last_byte;
         end
      end
   end

endmodule
